// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL; empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
// Check that a condition in one cycle implies another in the next cycle.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, expr)
`define ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== sv/duff_pkg.sv =====
// Types, constants, microcode and cosine table function for the Duffing RK4 block.
`default_nettype none
package duff_pkg;

    localparam int DEF_WORD_BITS       = 48;
    localparam int DEF_FRACTION_BITS   = 40;
    localparam int DEF_PHASE_BITS      = 32;
    localparam int DEF_COS_TABLE_DEPTH = 1024;

    localparam int MUL_BITS  = 64;
    localparam int COS_Q     = 31;
    localparam int TAYLOR_TERMS = 13;

    localparam logic [63:0] PI_Q60         = 64'h3243F6A8885A308D;
    localparam logic [63:0] INV_TWO_PI_Q64 = 64'h28BE60DB9391054A;
    localparam logic [63:0] RECIP6_Q64     = 64'h2AAAAAAAAAAAAAAA;

    localparam int CFG_INDEX_BITS = 4;
    localparam int PC_BITS = 7;
    localparam logic [PC_BITS-1:0] PC_LAST = 7'd69;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_STIFFNESS        = 4'd0,
        REG_NONLINEARITY     = 4'd1,
        REG_DAMPING          = 4'd2,
        REG_DRIVE_AMPLITUDE  = 4'd3,
        REG_DRIVE_FREQUENCY  = 4'd4,
        REG_STEP_SIZE        = 4'd5,
        REG_INITIAL_POSITION = 4'd6,
        REG_INITIAL_VELOCITY = 4'd7
    } cfg_reg_t;

    typedef enum logic [3:0] {
        OP_MUL, OP_ADD, OP_ADDC, OP_SUB, OP_DIV6, OP_PINC,
        OP_COS0, OP_COS1, OP_COS2, OP_END
    } op_t;

    typedef enum logic [4:0] {
        R_X, R_V, R_WT, R_C0, R_C1, R_C2, R_T0, R_T1, R_T2, R_T3, R_XE,
        R_K1V, R_K2X, R_K2V, R_K3X, R_K3V, R_K4X, R_K4V, R_S,
        R_ALPHA, R_BETA, R_DELTA, R_GAMMA, R_OMEGA, R_H, R_HH
    } sel_t;

    typedef struct packed {
        op_t  op;
        sel_t a;
        sel_t b;
        sel_t d;
    } uinstr_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_FETCH, ST_EXEC, ST_MUL, ST_MUL_FIN,
        ST_COS_RDA, ST_COS_RDB, ST_COS_DIFF, ST_OUT
    } state_t;

    function automatic uinstr_t ui(op_t o, sel_t a, sel_t b, sel_t d);
        uinstr_t u;
        u.op = o;
        u.a  = a;
        u.b  = b;
        u.d  = d;
        return u;
    endfunction

    // Acceleration x'' at (c, xe, ve) into kv, nine instructions from base.
    function automatic uinstr_t accel_ui(logic [3:0] k, sel_t c, sel_t xe, sel_t ve,
                                         sel_t kv);
        uinstr_t u;
        unique case (k)
            4'd0:    u = ui(OP_MUL, xe, xe, R_T0);
            4'd1:    u = ui(OP_MUL, R_T0, xe, R_T0);
            4'd2:    u = ui(OP_MUL, R_GAMMA, c, R_T1);
            4'd3:    u = ui(OP_MUL, R_DELTA, ve, R_T2);
            4'd4:    u = ui(OP_SUB, R_T1, R_T2, R_T1);
            4'd5:    u = ui(OP_MUL, R_ALPHA, xe, R_T2);
            4'd6:    u = ui(OP_SUB, R_T1, R_T2, R_T1);
            4'd7:    u = ui(OP_MUL, R_BETA, R_T0, R_T2);
            default: u = ui(OP_SUB, R_T1, R_T2, kv);
        endcase
        return u;
    endfunction

    function automatic uinstr_t ucode(logic [PC_BITS-1:0] pc);
        uinstr_t u;
        if (pc >= 7'd5 && pc <= 7'd13) begin
            u = accel_ui(4'(pc - 7'd5), R_C0, R_X, R_V, R_K1V);
        end else if (pc >= 7'd18 && pc <= 7'd26) begin
            u = accel_ui(4'(pc - 7'd18), R_C1, R_XE, R_K2X, R_K2V);
        end else if (pc >= 7'd31 && pc <= 7'd39) begin
            u = accel_ui(4'(pc - 7'd31), R_C1, R_XE, R_K3X, R_K3V);
        end else if (pc >= 7'd44 && pc <= 7'd52) begin
            u = accel_ui(4'(pc - 7'd44), R_C2, R_XE, R_K4X, R_K4V);
        end else begin
            unique case (pc)
                7'd0:    u = ui(OP_MUL, R_OMEGA, R_H, R_WT);
                7'd1:    u = ui(OP_PINC, R_WT, R_WT, R_WT);
                7'd2:    u = ui(OP_COS0, R_X, R_X, R_C0);
                7'd3:    u = ui(OP_COS1, R_X, R_X, R_C1);
                7'd4:    u = ui(OP_COS2, R_X, R_X, R_C2);
                7'd14:   u = ui(OP_MUL, R_HH, R_K1V, R_T3);
                7'd15:   u = ui(OP_ADD, R_V, R_T3, R_K2X);
                7'd16:   u = ui(OP_MUL, R_HH, R_V, R_T3);
                7'd17:   u = ui(OP_ADD, R_X, R_T3, R_XE);
                7'd27:   u = ui(OP_MUL, R_HH, R_K2V, R_T3);
                7'd28:   u = ui(OP_ADD, R_V, R_T3, R_K3X);
                7'd29:   u = ui(OP_MUL, R_HH, R_K2X, R_T3);
                7'd30:   u = ui(OP_ADD, R_X, R_T3, R_XE);
                7'd40:   u = ui(OP_MUL, R_H, R_K3V, R_T3);
                7'd41:   u = ui(OP_ADD, R_V, R_T3, R_K4X);
                7'd42:   u = ui(OP_MUL, R_H, R_K3X, R_T3);
                7'd43:   u = ui(OP_ADD, R_X, R_T3, R_XE);
                7'd53:   u = ui(OP_ADD, R_K2X, R_K2X, R_T3);
                7'd54:   u = ui(OP_ADD, R_V, R_T3, R_S);
                7'd55:   u = ui(OP_ADD, R_K3X, R_K3X, R_T3);
                7'd56:   u = ui(OP_ADD, R_S, R_T3, R_S);
                7'd57:   u = ui(OP_ADD, R_S, R_K4X, R_S);
                7'd58:   u = ui(OP_MUL, R_H, R_S, R_S);
                7'd59:   u = ui(OP_DIV6, R_S, R_S, R_S);
                7'd60:   u = ui(OP_ADDC, R_X, R_S, R_X);
                7'd61:   u = ui(OP_ADD, R_K2V, R_K2V, R_T3);
                7'd62:   u = ui(OP_ADD, R_K1V, R_T3, R_S);
                7'd63:   u = ui(OP_ADD, R_K3V, R_K3V, R_T3);
                7'd64:   u = ui(OP_ADD, R_S, R_T3, R_S);
                7'd65:   u = ui(OP_ADD, R_S, R_K4V, R_S);
                7'd66:   u = ui(OP_MUL, R_H, R_S, R_S);
                7'd67:   u = ui(OP_DIV6, R_S, R_S, R_S);
                7'd68:   u = ui(OP_ADDC, R_V, R_S, R_V);
                default: u = ui(OP_END, R_X, R_X, R_X);
            endcase
        end
        return u;
    endfunction

    // Cosine of a Q60 angle by Taylor series, rounded to unsigned Q1.31.
    function automatic logic [31:0] cos_entry(logic [63:0] x);
        logic [127:0] p;
        logic [63:0]  x2;
        logic [63:0]  term;
        logic [63:0]  sum;
        p = {64'd0, x} * {64'd0, x};
        x2 = p[123:60];
        term = 64'd1 << 60;
        sum = term;
        for (int n = 1; n <= TAYLOR_TERMS; n++) begin
            p = {64'd0, term} * {64'd0, x2};
            term = p[123:60] / 64'((2 * n - 1) * (2 * n));
            if ((n % 2) == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        return 32'((sum + (64'd1 << 28)) >> 29);
    endfunction

endpackage
`default_nettype wire

// ===== sv/duffing_oscillator_rk4_step.sv =====
// Driven Duffing oscillator advanced by one RK4 step per non-restart input beat.
`default_nettype none
`include "assert_macros.svh"
// Each input beat either restarts the oscillator (restart=1: load the initial
// position and velocity registers, zero the drive phase) or advances
// x'' = gamma*cos(phi) - delta*x' - alpha*x - beta*x^3 by one classical RK4
// step, and yields one output beat with position, velocity and a saturation
// flag. Values are signed fixed point, FRACTION_BITS fraction bits in a
// WORD_BITS word. A restart goes from idle straight to the output state; a
// step's run time is set by one shared 64x64 magnitude multiplier that
// needs four 32x32 passes per product and is used 36 times per step under a
// microcoded sequencer, plus three cosine lookups that read the quarter-wave
// ROM twice each. in_ready is high only while the sequencer is idle. A
// finished beat waits in the output register, so the next input beat is
// taken while it is held. Configuration writes are always ready and take
// effect at once; write them only while no step is in flight.
module duffing_oscillator_rk4_step #(
    parameter int WORD_BITS       = duff_pkg::DEF_WORD_BITS,
    parameter int FRACTION_BITS   = duff_pkg::DEF_FRACTION_BITS,
    parameter int PHASE_BITS      = duff_pkg::DEF_PHASE_BITS,
    parameter int COS_TABLE_DEPTH = duff_pkg::DEF_COS_TABLE_DEPTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                restart,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [WORD_BITS-1:0]         position,
    output logic signed [WORD_BITS-1:0]         velocity,
    output logic                                saturated,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [duff_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [WORD_BITS-1:0]                cfg_data
);
    import duff_pkg::*;

    localparam int W  = WORD_BITS;
    localparam int F  = FRACTION_BITS;
    localparam int P  = PHASE_BITS;
    localparam int QS = P - 2;
    localparam int IDX_BITS  = $clog2(COS_TABLE_DEPTH + 1);
    localparam int ADDR_BITS = $clog2(COS_TABLE_DEPTH);
    localparam int SC_BITS   = QS + 1 + IDX_BITS;
    localparam int PSH = MUL_BITS + F - P;
    localparam int CSH_L = (F >= COS_Q) ? F - COS_Q : 0;
    localparam int CSH_R = (F >= COS_Q) ? 0 : COS_Q - F;

    localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
    localparam logic [63:0]  LIM  = 64'd1 << (W - 1);
    localparam logic [QS:0]  QUARTER = {1'b1, {QS{1'b0}}};

    localparam logic [63:0] ONE   = 64'd1 << F;
    localparam logic [W-1:0] RST_ALPHA = W'(ONE);
    localparam logic [W-1:0] RST_BETA  = W'(ONE * 64'd5);
    localparam logic [W-1:0] RST_DELTA = W'((ONE * 64'd2 + 64'd50) / 64'd100);
    localparam logic [W-1:0] RST_GAMMA = W'(ONE * 64'd8);
    localparam logic [W-1:0] RST_OMEGA = W'(ONE >> 1);
    localparam logic [W-2:0] RST_STEP  = (W-1)'((ONE + 64'd24000) / 64'd48000);

    localparam logic [63:0] HALF_PI_Q60 = PI_Q60 >> 1;
    localparam logic [63:0] ANG_QUOT = HALF_PI_Q60 / COS_TABLE_DEPTH;
    localparam logic [63:0] ANG_REM  = HALF_PI_Q60 % COS_TABLE_DEPTH;

    // Quarter-wave cosine ROM, one registered read per cycle.
    logic [31:0] cos_rom [COS_TABLE_DEPTH];
    for (genvar gi = 0; gi < COS_TABLE_DEPTH; gi++) begin : g_rom
        localparam logic [63:0] ANG = ANG_QUOT * gi + (ANG_REM * gi) / COS_TABLE_DEPTH;
        assign cos_rom[gi] = cos_entry(ANG);
    end

    // Saturate a magnitude with sign into the word.
    function automatic logic [W-1:0] from_mag(logic neg, logic [63:0] m);
        logic [W-1:0] r;
        if (m >= LIM) begin
            r = neg ? WMIN : WMAX;
        end else begin
            r = neg ? W'(~m + 64'd1) : W'(m);
        end
        return r;
    endfunction

    function automatic logic [63:0] mag_of(logic [W-1:0] a);
        logic [W-1:0] m;
        m = a[W-1] ? (~a + W'(1)) : a;
        return 64'(m);
    endfunction

    function automatic logic [W:0] add_sat(logic [W-1:0] a, logic [W-1:0] b, logic sub);
        logic [W:0] s;
        logic       ovf;
        s = sub ? ({a[W-1], a} - {b[W-1], b}) : ({a[W-1], a} + {b[W-1], b});
        ovf = s[W] != s[W-1];
        if (ovf) begin
            return {1'b1, s[W] ? WMIN : WMAX};
        end
        return {1'b0, s[W-1:0]};
    endfunction

    // Configuration registers
    logic [W-1:0] alpha_reg, beta_reg, delta_reg, gamma_reg, omega_reg;
    logic [W-1:0] init_pos_reg, init_vel_reg;
    logic [W-2:0] step_reg;

    // Oscillator state and working registers
    logic [W-1:0] x_reg, v_reg;
    logic [P-1:0] phase_reg, inc_reg, half_reg;
    logic [W-1:0] wt_reg, c0_reg, c1_reg, c2_reg, t0_reg, t1_reg, t2_reg, t3_reg;
    logic [W-1:0] xe_reg, k1v_reg, k2x_reg, k2v_reg, k3x_reg, k3v_reg, k4x_reg, k4v_reg;
    logic [W-1:0] s_reg;
    logic         clip_reg;

    // Sequencer
    state_t              state_reg, state_next;
    logic [PC_BITS-1:0]  pc_reg;
    uinstr_t             instr_reg;
    uinstr_t             fetch_ui;
    logic [W-1:0]        opa_reg, opb_reg, opa_sel, opb_sel;

    // Shared multiplier
    logic [63:0]  mul_a_reg, mul_b_reg, mul_a_next, mul_b_next;
    logic [127:0] mul_acc_reg;
    logic [1:0]   mul_cnt_reg;
    logic         mul_load;
    logic [63:0]  mul_pp;
    logic [127:0] mul_pp_sh;

    // Cosine lookup
    logic [IDX_BITS-1:0] idx_reg;
    logic [QS-1:0]       frac_reg;
    logic [1:0]          quad_reg;
    logic [31:0]         ca_reg, rom_q_reg, cb_val;
    logic                ge_reg;
    logic [ADDR_BITS-1:0] rom_addr;
    logic [P-1:0]        cos_phase;
    logic [QS:0]         cos_u;
    logic [SC_BITS-1:0]  cos_scaled;
    logic                idx_a_ok, idx_b_ok;

    // Output register
    logic         out_valid_reg, sat_out_reg;
    logic [W-1:0] pos_out_reg, vel_out_reg;

    // Result of the instruction being finished
    logic [W-1:0] wb_val;
    logic         wb_en, wb_clip;
    logic [W:0]   alu_sum;
    logic [63:0]  div_q0, div_r, div_q, cos_interp, cos_val, cos_m;
    logic         mul_sat;

    logic in_fire, out_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign position  = pos_out_reg;
    assign velocity  = vel_out_reg;
    assign saturated = sat_out_reg;

    assign fetch_ui = ucode(pc_reg);

    always_comb
    begin
        opa_sel = '0;
        opb_sel = '0;
        for (int k = 0; k < 2; k++)
        begin
            logic [W-1:0] val;
            sel_t         s;
            s = (k == 0) ? fetch_ui.a : fetch_ui.b;
            unique case (s)
                R_X:     val = x_reg;
                R_V:     val = v_reg;
                R_WT:    val = wt_reg;
                R_C0:    val = c0_reg;
                R_C1:    val = c1_reg;
                R_C2:    val = c2_reg;
                R_T0:    val = t0_reg;
                R_T1:    val = t1_reg;
                R_T2:    val = t2_reg;
                R_T3:    val = t3_reg;
                R_XE:    val = xe_reg;
                R_K1V:   val = k1v_reg;
                R_K2X:   val = k2x_reg;
                R_K2V:   val = k2v_reg;
                R_K3X:   val = k3x_reg;
                R_K3V:   val = k3v_reg;
                R_K4X:   val = k4x_reg;
                R_K4V:   val = k4v_reg;
                R_S:     val = s_reg;
                R_ALPHA: val = alpha_reg;
                R_BETA:  val = beta_reg;
                R_DELTA: val = delta_reg;
                R_GAMMA: val = gamma_reg;
                R_OMEGA: val = omega_reg;
                R_H:     val = {1'b0, step_reg};
                R_HH:    val = {2'b00, step_reg[W-2:1]};
                default: val = '0;
            endcase
            if (k == 0) begin
                opa_sel = val;
            end else begin
                opb_sel = val;
            end
        end
    end

    // Cosine address: fold the phase into one quarter wave.
    always_comb
    begin
        unique case (instr_reg.op)
            OP_COS1: cos_phase = phase_reg + half_reg;
            OP_COS2: cos_phase = phase_reg + inc_reg;
            default: cos_phase = phase_reg;
        endcase
        cos_u = cos_phase[P-2] ? (QUARTER - {1'b0, cos_phase[QS-1:0]})
                               : {1'b0, cos_phase[QS-1:0]};
        cos_scaled = SC_BITS'(cos_u) * SC_BITS'(COS_TABLE_DEPTH);
    end

    assign idx_a_ok = (IDX_BITS + 1)'(idx_reg) < (IDX_BITS + 1)'(COS_TABLE_DEPTH);
    assign idx_b_ok = (IDX_BITS + 1)'(idx_reg) + (IDX_BITS + 1)'(1)
                      < (IDX_BITS + 1)'(COS_TABLE_DEPTH);
    assign rom_addr = (state_reg == ST_COS_RDB) ? ADDR_BITS'(idx_reg + IDX_BITS'(1))
                                                : ADDR_BITS'(idx_reg);
    assign cb_val   = idx_b_ok ? rom_q_reg : 32'd0;

    always_ff @(posedge clk)
    begin
        rom_q_reg <= cos_rom[rom_addr];
    end

    // Multiplier partial product for the current pass.
    always_comb
    begin
        logic [31:0] ah, bh;
        ah = mul_cnt_reg[1] ? mul_a_reg[63:32] : mul_a_reg[31:0];
        bh = mul_cnt_reg[0] ? mul_b_reg[63:32] : mul_b_reg[31:0];
        mul_pp = {32'd0, ah} * {32'd0, bh};
        unique case (mul_cnt_reg)
            2'd0:    mul_pp_sh = {64'd0, mul_pp};
            2'd3:    mul_pp_sh = {mul_pp, 64'd0};
            default: mul_pp_sh = {32'd0, mul_pp, 32'd0};
        endcase
    end

    // Finish arithmetic and drive the sequencer.
    always_comb
    begin
        state_next = state_reg;
        wb_en      = 1'b0;
        wb_clip    = 1'b0;
        wb_val     = '0;
        mul_load   = 1'b0;
        mul_a_next = 64'd0;
        mul_b_next = 64'd0;
        alu_sum    = add_sat(opa_reg, opb_reg, instr_reg.op == OP_SUB);
        mul_sat    = |(mul_acc_reg >> (F + W - 1));
        div_q0     = mul_acc_reg[127:64];
        div_r      = mag_of(opa_reg) - (div_q0 << 2) - (div_q0 << 1);
        div_q      = (div_r >= 64'd6) ? div_q0 + 64'd1 : div_q0;
        cos_interp = 64'(mul_acc_reg >> QS);
        cos_val    = ge_reg ? (64'(ca_reg) - cos_interp) : (64'(ca_reg) + cos_interp);
        cos_m      = (cos_val << CSH_L) >> CSH_R;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire) begin
                    state_next = restart ? ST_OUT : ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                state_next = (fetch_ui.op == OP_END) ? ST_OUT : ST_EXEC;
            end
            ST_EXEC:
            begin
                priority case (instr_reg.op)
                    OP_ADD, OP_ADDC, OP_SUB:
                    begin
                        wb_en      = 1'b1;
                        wb_val     = alu_sum[W-1:0];
                        wb_clip    = (instr_reg.op == OP_ADDC) && alu_sum[W];
                        state_next = ST_FETCH;
                    end
                    OP_COS0, OP_COS1, OP_COS2:
                    begin
                        state_next = ST_COS_RDA;
                    end
                    default:
                    begin
                        mul_load   = 1'b1;
                        mul_a_next = mag_of(opa_reg);
                        priority case (instr_reg.op)
                            OP_DIV6: mul_b_next = RECIP6_Q64;
                            OP_PINC: mul_b_next = INV_TWO_PI_Q64;
                            default: mul_b_next = mag_of(opb_reg);
                        endcase
                        state_next = ST_MUL;
                    end
                endcase
            end
            ST_COS_RDA:
            begin
                state_next = ST_COS_RDB;
            end
            ST_COS_RDB:
            begin
                state_next = ST_COS_DIFF;
            end
            ST_COS_DIFF:
            begin
                mul_load   = 1'b1;
                mul_a_next = (ca_reg >= cb_val) ? 64'(ca_reg - cb_val) : 64'(cb_val - ca_reg);
                mul_b_next = 64'(frac_reg);
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                if (mul_cnt_reg == 2'd3) begin
                    state_next = ST_MUL_FIN;
                end
            end
            ST_MUL_FIN:
            begin
                wb_en = (instr_reg.op != OP_PINC);
                priority case (instr_reg.op)
                    OP_DIV6:
                        wb_val = opa_reg[W-1] ? W'(~div_q + 64'd1) : W'(div_q);
                    OP_COS0, OP_COS1, OP_COS2:
                        wb_val = from_mag(quad_reg[1] ^ quad_reg[0], cos_m);
                    default:
                        wb_val = from_mag(opa_reg[W-1] ^ opb_reg[W-1],
                                          mul_sat ? LIM : 64'(mul_acc_reg >> F));
                endcase
                state_next = ST_FETCH;
            end
            ST_OUT:
            begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            alpha_reg    <= RST_ALPHA;
            beta_reg     <= RST_BETA;
            delta_reg    <= RST_DELTA;
            gamma_reg    <= RST_GAMMA;
            omega_reg    <= RST_OMEGA;
            step_reg     <= RST_STEP;
            init_pos_reg <= '0;
            init_vel_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_STIFFNESS:        alpha_reg    <= cfg_data;
                REG_NONLINEARITY:     beta_reg     <= cfg_data;
                REG_DAMPING:          delta_reg    <= cfg_data;
                REG_DRIVE_AMPLITUDE:  gamma_reg    <= cfg_data;
                REG_DRIVE_FREQUENCY:  omega_reg    <= cfg_data;
                REG_STEP_SIZE:        step_reg     <= cfg_data[W-2:0];
                REG_INITIAL_POSITION: init_pos_reg <= cfg_data;
                REG_INITIAL_VELOCITY: init_vel_reg <= cfg_data;
                default:              ;
            endcase
        end
    end

    // Oscillator state, phase, flag and output beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            x_reg         <= '0;
            v_reg         <= '0;
            phase_reg     <= '0;
            clip_reg      <= 1'b0;
            pc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            // Load a new beat when the output slot frees up, else drop the taken one.
            if (state_reg == ST_OUT && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (out_valid_reg && out_ready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire) begin
                        // Restart loads the initial state; a step runs the program.
                        clip_reg <= 1'b0;
                        pc_reg   <= '0;
                        if (restart) begin
                            x_reg     <= init_pos_reg;
                            v_reg     <= init_vel_reg;
                            phase_reg <= '0;
                        end
                    end
                end
                ST_FETCH:
                begin
                    if (fetch_ui.op == OP_END) begin
                        phase_reg <= phase_reg + inc_reg;
                    end else begin
                        pc_reg <= pc_reg + PC_BITS'(1);
                    end
                end
                ST_OUT:       ;
                default:
                begin
                    if (wb_clip) begin
                        clip_reg <= 1'b1;
                    end
                    if (wb_en && instr_reg.d == R_X) begin
                        x_reg <= wb_val;
                    end
                    if (wb_en && instr_reg.d == R_V) begin
                        v_reg <= wb_val;
                    end
                end
            endcase
        end
    end

    // Payload registers of the datapath
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_OUT && out_free) begin
            pos_out_reg <= x_reg;
            vel_out_reg <= v_reg;
            sat_out_reg <= clip_reg;
        end
        if (state_reg == ST_FETCH) begin
            instr_reg <= fetch_ui;
            opa_reg   <= opa_sel;
            opb_reg   <= opb_sel;
        end
        if (state_reg == ST_EXEC) begin
            idx_reg  <= IDX_BITS'(cos_scaled >> QS);
            frac_reg <= cos_scaled[QS-1:0];
            quad_reg <= cos_phase[P-1:P-2];
        end
        if (state_reg == ST_COS_RDB) begin
            ca_reg <= idx_a_ok ? rom_q_reg : 32'd0;
        end
        if (state_reg == ST_COS_DIFF) begin
            ge_reg <= ca_reg >= cb_val;
        end
        if (mul_load) begin
            mul_a_reg   <= mul_a_next;
            mul_b_reg   <= mul_b_next;
            mul_acc_reg <= '0;
            mul_cnt_reg <= 2'd0;
        end else if (state_reg == ST_MUL) begin
            mul_acc_reg <= mul_acc_reg + mul_pp_sh;
            mul_cnt_reg <= mul_cnt_reg + 2'd1;
        end
        if (state_reg == ST_MUL_FIN && instr_reg.op == OP_PINC) begin
            // Turn omega*h into a phase increment; negate for a negative drive.
            if (opa_reg[W-1]) begin
                inc_reg  <= ~P'(mul_acc_reg >> PSH) + P'(1);
                half_reg <= ~(P'(mul_acc_reg >> PSH) >> 1) + P'(1);
            end else begin
                inc_reg  <= P'(mul_acc_reg >> PSH);
                half_reg <= P'(mul_acc_reg >> PSH) >> 1;
            end
        end
        if (wb_en) begin
            unique case (instr_reg.d)
                R_WT:    wt_reg  <= wb_val;
                R_C0:    c0_reg  <= wb_val;
                R_C1:    c1_reg  <= wb_val;
                R_C2:    c2_reg  <= wb_val;
                R_T0:    t0_reg  <= wb_val;
                R_T1:    t1_reg  <= wb_val;
                R_T2:    t2_reg  <= wb_val;
                R_T3:    t3_reg  <= wb_val;
                R_XE:    xe_reg  <= wb_val;
                R_K1V:   k1v_reg <= wb_val;
                R_K2X:   k2x_reg <= wb_val;
                R_K2V:   k2v_reg <= wb_val;
                R_K3X:   k3x_reg <= wb_val;
                R_K3V:   k3v_reg <= wb_val;
                R_K4X:   k4x_reg <= wb_val;
                R_K4V:   k4v_reg <= wb_val;
                R_S:     s_reg   <= wb_val;
                default: ;
            endcase
        end
    end

    `ASSERT_NEXT(a_restart_to_out, in_valid && in_ready && restart, state_reg == ST_OUT)
    `ASSERT_NEXT(a_mul_four_passes, state_reg == ST_MUL && mul_cnt_reg == 2'd3, state_reg == ST_MUL_FIN)
    `ASSERT_ALWAYS(a_pc_in_program, state_reg == ST_IDLE || pc_reg <= PC_LAST)
    `ASSERT_NEXT(a_out_only_from_seq, !out_valid_reg && state_reg != ST_OUT, !out_valid_reg)

endmodule
`default_nettype wire
